// ===== rtl/ger_pkg.sv =====
// shared types and codes for the gear event recorder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ger_pkg;

	localparam int GER_LOG_SLOTS = 10;

	localparam logic [2:0] OP_IDLE    = 3'd0;
	localparam logic [2:0] OP_UP      = 3'd1;
	localparam logic [2:0] OP_DOWN    = 3'd2;
	localparam logic [2:0] OP_COLLIDE = 3'd3;
	localparam logic [2:0] OP_READ    = 3'd4;
	localparam logic [2:0] OP_CLEAR   = 3'd5;

	localparam logic [3:0] GEAR_NEUTRAL = 4'd0;
	localparam logic [3:0] GEAR_REVERSE = 4'd6;
	localparam logic [3:0] GEAR_COLLIDE = 4'd7;
	localparam logic [3:0] GEAR_ON      = 4'd8;

	typedef struct packed {
		logic [2:0] operation;
		logic [4:0] stamp_hour;
		logic [5:0] stamp_minute;
		logic [5:0] stamp_second;
		logic [6:0] vehicle_speed;
		logic [3:0] read_index;
	} item_t;

	typedef struct packed {
		logic [3:0] current_gear;
		logic [1:0] events_recorded;
		logic [3:0] events_held;
		logic       entry_valid;
		logic [4:0] entry_hour;
		logic [5:0] entry_minute;
		logic [5:0] entry_second;
		logic [3:0] entry_gear;
		logic [6:0] entry_speed;
	} result_t;

	// one log record, 28 bits
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [3:0] gear;
		logic [6:0] speed;
	} record_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic second;
		logic rdout;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic two_rec;
		logic is_read;
	} status_t;

endpackage

// ===== rtl/ger_ctrl.sv =====
// sequencer of the gear event recorder: steps each item through its cycles
// depends on ger_pkg
`timescale 1ns / 1ps

module ger_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  ger_pkg::status_t status,
	output ger_pkg::cmd_t    cmd,
	output logic             busy
);
	import ger_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_SECOND = 2'd2;
	localparam logic [1:0] ST_RDOUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (status.is_read) begin
					state_nx = ST_RDOUT;
				end else if (status.two_rec) begin
					state_nx = ST_SECOND;
				end else begin
					cmd.finish = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			ST_SECOND: begin
				cmd.second = 1'b1;
				cmd.finish = 1'b1;
				state_nx = ST_IDLE;
			end
			ST_RDOUT: begin
				cmd.rdout = 1'b1;
				cmd.finish = 1'b1;
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ===== rtl/ger_datapath.sv =====
// gear state, circular log memory and result register of the recorder
// depends on ger_pkg
`timescale 1ns / 1ps

module ger_datapath #(
	parameter int LOG_SLOTS = ger_pkg::GER_LOG_SLOTS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ger_pkg::item_t   item,
	input  ger_pkg::cmd_t    cmd,
	output ger_pkg::status_t status,
	output logic             done,
	output ger_pkg::result_t result
);
	import ger_pkg::*;

	localparam int SLOT_W = $clog2(LOG_SLOTS);
	localparam int CNT_W  = $clog2(LOG_SLOTS + 1);
	localparam int BASE_W = (CNT_W > 4) ? CNT_W : 4;
	localparam int AW     = BASE_W + 2;

	item_t              item_q;
	logic [3:0]         gear_q, gear_nx;
	logic               coll_q, coll_nx;
	logic               on_done_q, on_done_nx;
	logic [SLOT_W-1:0]  slot_q, slot_nx;
	logic [CNT_W-1:0]   held_q, held_nx;
	logic [1:0]         rec_q, rec_nx;
	logic               valid_q;
	logic               done_q;
	result_t            result_q, res_nx;

	record_t            mem_q [LOG_SLOTS];
	record_t            rd_q;
	record_t            wr_rec;
	logic               wr_en;
	logic [3:0]         wr_gear;

	logic [2:0]         op;
	logic               is_gear_op;
	logic               need_on;
	logic               chg;
	logic [3:0]         gear_new;
	logic               coll_new;

	logic [AW-1:0]      ws_ext, held_ext, idx_ext, oldest, slot_sum;
	logic [SLOT_W-1:0]  rd_addr;
	logic               rd_valid;
	logic [31:0]        held_wide;

	// gear step decision for the item held in item_q
	always_comb begin
		op = item_q.operation;
		is_gear_op = (op == OP_IDLE) || (op == OP_UP) || (op == OP_DOWN) ||
			(op == OP_COLLIDE);
		chg = 1'b0;
		gear_new = gear_q;
		coll_new = coll_q;
		if ((op == OP_UP) || (op == OP_DOWN)) begin
			if (coll_q) begin
				chg = 1'b1;
				gear_new = GEAR_NEUTRAL;
				coll_new = 1'b0;
			end else if ((op == OP_UP) && (gear_q < GEAR_REVERSE)) begin
				chg = 1'b1;
				gear_new = 4'(gear_q + 4'd1);
			end else if ((op == OP_DOWN) && (gear_q != GEAR_NEUTRAL)) begin
				chg = 1'b1;
				gear_new = 4'(gear_q - 4'd1);
			end
		end else if ((op == OP_COLLIDE) && (gear_q != GEAR_COLLIDE)) begin
			chg = 1'b1;
			gear_new = GEAR_COLLIDE;
			coll_new = 1'b1;
		end
		need_on = is_gear_op && !on_done_q;
		status.two_rec = need_on && chg;
		status.is_read = (op == OP_READ);
	end

	// read address: oldest slot plus index, wrapped
	always_comb begin
		ws_ext   = AW'(slot_q);
		held_ext = AW'(held_q);
		idx_ext  = AW'(item_q.read_index);
		oldest   = ws_ext + AW'(LOG_SLOTS) - held_ext;
		if (oldest >= AW'(LOG_SLOTS)) begin
			oldest = oldest - AW'(LOG_SLOTS);
		end
		slot_sum = oldest + idx_ext;
		if (slot_sum >= AW'(LOG_SLOTS)) begin
			slot_sum = slot_sum - AW'(LOG_SLOTS);
		end
		rd_addr  = slot_sum[SLOT_W-1:0];
		rd_valid = (idx_ext < held_ext);
	end

	// next state of the gear and log pointers
	always_comb begin
		gear_nx    = gear_q;
		coll_nx    = coll_q;
		on_done_nx = on_done_q;
		rec_nx     = rec_q;
		slot_nx    = slot_q;
		held_nx    = held_q;
		wr_en      = 1'b0;
		wr_gear    = gear_q;
		if (cmd.exec) begin
			rec_nx = 2'd0;
			if (is_gear_op) begin
				on_done_nx = 1'b1;
				gear_nx    = gear_new;
				coll_nx    = coll_new;
				wr_en      = need_on || chg;
				// on event goes first and keeps the gear it was logged with
				wr_gear    = need_on ? gear_q : gear_new;
				rec_nx     = {1'b0, wr_en};
			end
			if (op == OP_CLEAR) begin
				slot_nx = '0;
				held_nx = '0;
			end
		end
		if (cmd.second) begin
			wr_en   = 1'b1;
			wr_gear = gear_q;
			rec_nx  = 2'(rec_q + 2'd1);
		end
		if (wr_en) begin
			slot_nx = (slot_q == SLOT_W'(LOG_SLOTS - 1)) ? '0 : SLOT_W'(slot_q + 1'b1);
			if (held_q < CNT_W'(LOG_SLOTS)) begin
				held_nx = CNT_W'(held_q + 1'b1);
			end
		end
	end

	always_comb begin
		wr_rec.hour   = item_q.stamp_hour;
		wr_rec.minute = item_q.stamp_minute;
		wr_rec.second = item_q.stamp_second;
		wr_rec.gear   = wr_gear;
		wr_rec.speed  = item_q.vehicle_speed;
	end

	always_comb begin
		held_wide = 32'(held_nx);
		res_nx = '0;
		res_nx.current_gear    = gear_nx;
		res_nx.events_recorded = rec_nx;
		res_nx.events_held     = held_wide[3:0];
		if (cmd.rdout && valid_q) begin
			res_nx.entry_valid  = 1'b1;
			res_nx.entry_hour   = rd_q.hour;
			res_nx.entry_minute = rd_q.minute;
			res_nx.entry_second = rd_q.second;
			res_nx.entry_gear   = rd_q.gear;
			res_nx.entry_speed  = rd_q.speed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_q    <= GEAR_ON;
			coll_q    <= 1'b1;
			on_done_q <= 1'b0;
			slot_q    <= '0;
			held_q    <= '0;
			rec_q     <= '0;
			valid_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			gear_q    <= gear_nx;
			coll_q    <= coll_nx;
			on_done_q <= on_done_nx;
			slot_q    <= slot_nx;
			held_q    <= held_nx;
			rec_q     <= rec_nx;
			done_q    <= cmd.finish;
			if (cmd.exec) begin
				valid_q <= rd_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.finish) begin
			result_q <= res_nx;
		end
	end

	// log memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[slot_q] <= wr_rec;
		end
		if (cmd.exec) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/gear_event_recorder.sv =====
// Gear event recorder top level: controller plus datapath with the log memory
// depends on ger_pkg, ger_ctrl, ger_datapath
//
// Usage:
//   An item is taken on a rising edge with start high and busy low. The
//   item carries an operation (idle, gear up, gear down, collision, read
//   entry, clear log), a time stamp, a speed and a read index.
//   Exactly one result per item appears on result for one cycle with done
//   high; the receiver cannot stall it and must take it in that cycle.
//   done and result are registered from an item's last state: execute for
//   most items, readout for a read entry (registered memory read), and the
//   second-write state for the first gear item after reset that changes the
//   gear and so logs the on event too (two memory writes through the single
//   write port). busy is high while an item is in progress and drops in the
//   cycle the result is shown, so the next item can be taken then.
//   Reset sets the gear to on with collision pending and empties the log;
//   log contents are not cleared and only written slots are ever read.
`timescale 1ns / 1ps

module gear_event_recorder #(
	parameter int LOG_SLOTS = ger_pkg::GER_LOG_SLOTS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  ger_pkg::item_t   item,
	output logic             busy,
	output logic             done,
	output ger_pkg::result_t result
);
	import ger_pkg::*;

	cmd_t    cmd;
	status_t status;

	ger_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	ger_datapath #(
		.LOG_SLOTS (LOG_SLOTS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.done   (done),
		.result (result)
	);

endmodule

// ===== rtl/ger_checker.sv =====
// port-level checks of the gear event recorder, bound to the top level
// depends on ger_pkg and gear_event_recorder
`timescale 1ns / 1ps

module ger_port_checks (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input ger_pkg::result_t result
);
	import ger_pkg::*;

	// a taken beat keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	// a result only follows work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in progress");

	// one result per item, never two in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// a read logs nothing
	a_read_no_log: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.entry_valid |-> result.events_recorded == 2'd0)
		else $error("read result reports logged events");

	// at most two records per item
	a_rec_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.events_recorded != 2'd3)
		else $error("record count out of range");

endmodule

bind gear_event_recorder ger_port_checks u_ger_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
